[rtl/tpm_pkg.sv]
// Shared constants for the traffic power mode policy block.
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TOTAL_WIDTH = 17;
	localparam int STAMP_WIDTH = 32;
	localparam int THRESH_WIDTH = 16;
	localparam int ADDR_WIDTH = 4;
	localparam int APB_DATA_WIDTH = 32;
	localparam int IN_TDATA_WIDTH = 40;
	localparam int IN_TUSER_WIDTH = 3;
	localparam int OUT_TDATA_WIDTH = 24;

	typedef logic [2:0] op_t;
	localparam op_t OP_TX = 3'd0;
	localparam op_t OP_RX = 3'd1;
	localparam op_t OP_TICK = 3'd2;
	localparam op_t OP_SESSION = 3'd3;
	localparam op_t OP_HOSTSLEEP = 3'd4;
	localparam op_t OP_DONE = 3'd5;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_EXIT = 2'd0;
	localparam cmd_t CMD_ENTER = 2'd1;
	localparam cmd_t CMD_UAPSD = 2'd2;
	localparam cmd_t CMD_HSCFG = 2'd3;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_ACTIVE = 2'd0;
	localparam mode_t MODE_PS = 2'd1;
	localparam mode_t MODE_UAPSD = 2'd2;
	localparam mode_t MODE_UAPSD_ALT = 2'd3;

	localparam logic [ADDR_WIDTH-1:0] ADDR_METER_ENABLE = 4'h0;
	localparam logic [ADDR_WIDTH-1:0] ADDR_EXIT_THRESHOLD = 4'h4;
	localparam logic [ADDR_WIDTH-1:0] ADDR_ENTER_THRESHOLD = 4'h8;
	localparam logic [ADDR_WIDTH-1:0] ADDR_GAP_LIMIT = 4'hC;

	localparam logic [THRESH_WIDTH-1:0] EXIT_THRESHOLD_RESET = 16'd20;
	localparam logic [THRESH_WIDTH-1:0] ENTER_THRESHOLD_RESET = 16'd5;
	localparam logic [THRESH_WIDTH-1:0] GAP_LIMIT_RESET = 16'd10;

	typedef struct packed {
		op_t operation;
		logic [STAMP_WIDTH-1:0] timestamp;
		mode_t power_mode;
		logic session_kind;
		logic session_register;
		logic link_connected;
	} item_t;

	typedef struct packed {
		logic command_valid;
		cmd_t command;
		logic meter_armed;
		logic command_pending;
		logic [TOTAL_WIDTH-1:0] traffic_total;
	} result_t;

endpackage
`default_nettype wire

[rtl/traffic_power_mode_policy.sv]
// Top level of the traffic power mode policy block.
//
// Picks the radio power mode command from packet traffic. Each stream transfer
// is one event (selected by s_axis_tuser) and yields exactly one result transfer.
// An event is taken into an input register, evaluated combinationally against
// the counters, the last two tx and rx timestamps and the session flags, and
// written into the result register together with the state update. Throughput
// is one event per clock while m_axis_tready does not hold back the result.
// Only the newest two stamps of each direction are kept, as nothing older is
// ever consulted. Registers sit on an APB port at byte addresses 0, 4, 8, 12.
`timescale 1ns / 1ps
`default_nettype none
module traffic_power_mode_policy (
	input wire logic clk,
	input wire logic arst_n,
	// stream in
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// timestamp[31:0], power_mode[33:32], session_kind[34],
	// session_register[35], link_connected[36], zero pad [39:37]
	input wire logic [tpm_pkg::IN_TDATA_WIDTH-1:0] s_axis_tdata,
	// operation[2:0]
	input wire logic [tpm_pkg::IN_TUSER_WIDTH-1:0] s_axis_tuser,
	// stream out
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// command_valid[0], command[2:1], meter_armed[3], command_pending[4],
	// traffic_total[21:5], zero pad [23:22]
	output logic [tpm_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	// APB
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tpm_pkg::ADDR_WIDTH-1:0] paddr,
	input wire logic [tpm_pkg::APB_DATA_WIDTH-1:0] pwdata,
	output logic [tpm_pkg::APB_DATA_WIDTH-1:0] prdata,
	output logic pready
);
	import tpm_pkg::*;

	// configuration
	logic meter_enable_q;
	logic [THRESH_WIDTH-1:0] exit_threshold_q;
	logic [THRESH_WIDTH-1:0] enter_threshold_q;
	logic [THRESH_WIDTH-1:0] gap_limit_q;
	logic cfg_write;

	// state
	logic [COUNT_WIDTH-1:0] tx_count_q, rx_count_q;
	logic [STAMP_WIDTH-1:0] tx_new_q, tx_old_q, rx_new_q, rx_old_q;
	logic armed_q, pending_q, data_flag_q, voice_flag_q;
	cmd_t pending_code_q;

	// pipeline
	logic s1_valid_q;
	item_t item_s1;
	logic out_valid_q;
	result_t result_s2;
	logic advance;

	// next-state values
	logic [COUNT_WIDTH-1:0] tx_count_d, rx_count_d;
	logic [STAMP_WIDTH-1:0] tx_new_d, tx_old_d, rx_new_d, rx_old_d;
	logic armed_d, pending_d, data_flag_d, voice_flag_d;
	cmd_t pending_code_d;
	result_t result_d;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr)
			ADDR_METER_ENABLE: prdata = {{(APB_DATA_WIDTH-1){1'b0}}, meter_enable_q};
			ADDR_EXIT_THRESHOLD: prdata = {{(APB_DATA_WIDTH-THRESH_WIDTH){1'b0}},
				exit_threshold_q};
			ADDR_ENTER_THRESHOLD: prdata = {{(APB_DATA_WIDTH-THRESH_WIDTH){1'b0}},
				enter_threshold_q};
			ADDR_GAP_LIMIT: prdata = {{(APB_DATA_WIDTH-THRESH_WIDTH){1'b0}}, gap_limit_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_enable_q <= 1'b1;
			exit_threshold_q <= EXIT_THRESHOLD_RESET;
			enter_threshold_q <= ENTER_THRESHOLD_RESET;
			gap_limit_q <= GAP_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (paddr)
				ADDR_METER_ENABLE: meter_enable_q <= pwdata[0];
				ADDR_EXIT_THRESHOLD: exit_threshold_q <= pwdata[THRESH_WIDTH-1:0];
				ADDR_ENTER_THRESHOLD: enter_threshold_q <= pwdata[THRESH_WIDTH-1:0];
				ADDR_GAP_LIMIT: gap_limit_q <= pwdata[THRESH_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// handshake: input register frees when its item moves to the result register
	assign advance = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, result_s2.traffic_total, result_s2.command_pending,
		result_s2.meter_armed, result_s2.command, result_s2.command_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation <= s_axis_tuser;
			item_s1.timestamp <= s_axis_tdata[31:0];
			item_s1.power_mode <= s_axis_tdata[33:32];
			item_s1.session_kind <= s_axis_tdata[34];
			item_s1.session_register <= s_axis_tdata[35];
			item_s1.link_connected <= s_axis_tdata[36];
		end
	end

	// event evaluation
	always_comb begin
		logic [COUNT_WIDTH-1:0] tx_c, rx_c;
		logic [TOTAL_WIDTH-1:0] total;
		mode_t mode;
		logic is_pkt, record, dense, issue, keep;
		cmd_t code;
		logic [STAMP_WIDTH-1:0] t1, t2, r1, r2, tgap, rgap, skew;
		logic [STAMP_WIDTH-1:0] limit;

		tx_c = tx_count_q;
		rx_c = rx_count_q;
		if (item_s1.operation == OP_TX && tx_count_q != '1) begin
			tx_c = tx_count_q + 1'b1;
		end
		if (item_s1.operation == OP_RX && rx_count_q != '1) begin
			rx_c = rx_count_q + 1'b1;
		end
		total = TOTAL_WIDTH'({1'b0, tx_c} + {1'b0, rx_c});

		mode = (item_s1.power_mode == MODE_UAPSD_ALT) ? MODE_UAPSD : item_s1.power_mode;

		tx_count_d = tx_c;
		rx_count_d = rx_c;
		tx_new_d = tx_new_q;
		tx_old_d = tx_old_q;
		rx_new_d = rx_new_q;
		rx_old_d = rx_old_q;
		armed_d = armed_q;
		pending_d = pending_q;
		pending_code_d = pending_code_q;
		data_flag_d = data_flag_q;
		voice_flag_d = voice_flag_q;
		issue = 1'b0;
		code = CMD_EXIT;
		keep = 1'b1;

		is_pkt = item_s1.operation == OP_TX || item_s1.operation == OP_RX;
		record = is_pkt && meter_enable_q && !armed_q;
		if (record && item_s1.operation == OP_TX) begin
			tx_new_d = item_s1.timestamp;
			tx_old_d = tx_new_q;
		end
		if (record && item_s1.operation == OP_RX) begin
			rx_new_d = item_s1.timestamp;
			rx_old_d = rx_new_q;
		end
		t1 = tx_new_d;
		t2 = tx_old_d;
		r1 = rx_new_d;
		r2 = rx_old_d;
		tgap = t1 - t2;
		rgap = r1 - r2;
		skew = (r1 > t1) ? (r1 - t1) : (t1 - r1);
		limit = {{(STAMP_WIDTH-THRESH_WIDTH){1'b0}}, gap_limit_q};
		dense = (tgap < limit) && (rgap < limit) && (skew < limit);

		unique case (item_s1.operation)
			OP_TX, OP_RX: begin
				if (record) begin
					if (data_flag_q) begin
						issue = 1'b1;
						code = CMD_EXIT;
					end else if (voice_flag_q) begin
						issue = 1'b1;
						code = CMD_UAPSD;
					end else if (dense) begin
						issue = 1'b1;
						code = CMD_EXIT;
					end
				end
			end
			OP_TICK: begin
				if (armed_q) begin
					if (!meter_enable_q) begin
						keep = 1'b0;
					end else if (!pending_q) begin
						priority if (data_flag_q) begin
							if (mode != MODE_ACTIVE) begin
								issue = 1'b1;
								code = CMD_EXIT;
							end
						end else if (mode == MODE_UAPSD) begin
							if (!voice_flag_q) begin
								issue = 1'b1;
								if (total >= {1'b0, exit_threshold_q}) begin
									code = CMD_EXIT;
								end else begin
									code = CMD_ENTER;
									keep = 1'b0;
								end
							end
						end else if (mode == MODE_PS) begin
							priority if (voice_flag_q) begin
								issue = 1'b1;
								code = CMD_UAPSD;
							end else if (total >= {1'b0, exit_threshold_q}) begin
								issue = 1'b1;
								code = CMD_EXIT;
							end else begin
								keep = 1'b0;
							end
						end else begin
							if (voice_flag_q) begin
								issue = 1'b1;
								code = CMD_UAPSD;
							end else if (total <= {1'b0, enter_threshold_q}) begin
								issue = 1'b1;
								code = CMD_ENTER;
								keep = 1'b0;
							end
						end
					end
					tx_count_d = '0;
					rx_count_d = '0;
					armed_d = keep;
				end
			end
			OP_SESSION: begin
				if (item_s1.session_kind) begin
					voice_flag_d = item_s1.session_register;
				end else begin
					data_flag_d = item_s1.session_register;
				end
			end
			OP_HOSTSLEEP: begin
				if (meter_enable_q) begin
					issue = 1'b1;
					code = CMD_HSCFG;
				end
			end
			OP_DONE: begin
				if (pending_q) begin
					if (!meter_enable_q) begin
						armed_d = 1'b0;
					end else if (pending_code_q == CMD_EXIT || pending_code_q == CMD_UAPSD) begin
						if (item_s1.link_connected) begin
							if (!armed_q) begin
								tx_count_d = '0;
								rx_count_d = '0;
								armed_d = 1'b1;
							end
						end else begin
							armed_d = 1'b0;
						end
					end else if (pending_code_q == CMD_ENTER) begin
						armed_d = 1'b0;
					end
					pending_d = 1'b0;
					pending_code_d = CMD_EXIT;
				end
			end
			default: ;
		endcase

		// a command goes out only with metering on and nothing outstanding
		if (!meter_enable_q || pending_q) begin
			issue = 1'b0;
		end
		if (issue) begin
			pending_d = 1'b1;
			pending_code_d = code;
		end else begin
			code = CMD_EXIT;
		end

		result_d.command_valid = issue;
		result_d.command = code;
		result_d.meter_armed = armed_d;
		result_d.command_pending = pending_d;
		result_d.traffic_total = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_count_q <= '0;
			rx_count_q <= '0;
			tx_new_q <= '0;
			tx_old_q <= '0;
			rx_new_q <= '0;
			rx_old_q <= '0;
			armed_q <= 1'b0;
			pending_q <= 1'b0;
			pending_code_q <= CMD_EXIT;
			data_flag_q <= 1'b0;
			voice_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				tx_count_q <= tx_count_d;
				rx_count_q <= rx_count_d;
				tx_new_q <= tx_new_d;
				tx_old_q <= tx_old_d;
				rx_new_q <= rx_new_d;
				rx_old_q <= rx_old_d;
				armed_q <= armed_d;
				pending_q <= pending_d;
				pending_code_q <= pending_code_d;
				data_flag_q <= data_flag_d;
				voice_flag_q <= voice_flag_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

endmodule
`default_nettype wire
